@@ rtl/core/bfa_pkg.sv @@
`timescale 1ns / 1ps

package bfa_pkg;

    localparam int POS_BITS  = 24;
    localparam int LEN_BITS  = 12;
    localparam int SIZE_BITS = 13;
    localparam int PAGE_BITS = 12;

    localparam logic [PAGE_BITS-1:0] PAGE_MAX = {PAGE_BITS{1'b1}};

    localparam logic       OP_ALLOC = 1'b0;
    localparam logic       OP_FREE  = 1'b1;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_BIG  = 2'd2;

    typedef struct packed {
        logic                 op;
        logic [LEN_BITS-1:0]  value_length;
        logic [POS_BITS-1:0]  free_position;
    } req_t;

    typedef struct packed {
        logic [POS_BITS-1:0]  position;
        logic [1:0]           status;
        logic [PAGE_BITS-1:0] page_count;
    } rsp_t;

    typedef struct packed {
        logic [POS_BITS-1:0]  start;
        logic [SIZE_BITS-1:0] size;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_PAGE,
        ST_PLACE,
        ST_FINISH,
        ST_DROP_RD,
        ST_DROP_WR,
        ST_INS_RD,
        ST_INS_CHK,
        ST_INS_POS,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_INS_WR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic set_full;
        logic set_big;
        logic scan_init;
        logic rd_cur;
        logic rd_next;
        logic rd_prev;
        logic idx_inc;
        logic idx_dec;
        logic pick_tail;
        logic pick_entry;
        logic calc_limit;
        logic page_adjust;
        logic finish_alloc;
        logic used_dec;
        logic used_inc;
        logic ins_chk;
        logic ins_pos;
        logic wr_move;
        logic wr_ins;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic op;
        logic full;
        logic need_big;
        logic idx_end;
        logic fit;
        logic less;
        logic drop_last;
        logic at_k;
        logic from_tail;
        logic has_rem;
        logic out_free;
    } stat_t;

endpackage

@@ rtl/core/bfa_ram.sv @@
`timescale 1ns / 1ps

module bfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/bfa_ctrl.sv @@
`timescale 1ns / 1ps

module bfa_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  bfa_pkg::stat_t stat,
    output bfa_pkg::cmd_t  cmd
);
    import bfa_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (s_valid) state_next = ST_DECODE;
            ST_DECODE: begin
                if (stat.op == OP_FREE) begin
                    state_next = stat.full ? ST_DONE : ST_INS_RD;
                end else begin
                    state_next = stat.need_big ? ST_DONE : ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:  state_next = stat.idx_end ? ST_PAGE : ST_SCAN_CHK;
            ST_SCAN_CHK: state_next = stat.fit ? ST_PAGE : ST_SCAN_RD;
            ST_PAGE:     state_next = ST_PLACE;
            ST_PLACE:    state_next = ST_FINISH;
            ST_FINISH:   state_next = stat.from_tail ? ST_DONE : ST_DROP_RD;
            ST_DROP_RD: begin
                if (stat.drop_last) begin
                    state_next = stat.has_rem ? ST_INS_RD : ST_DONE;
                end else begin
                    state_next = ST_DROP_WR;
                end
            end
            ST_DROP_WR:  state_next = ST_DROP_RD;
            ST_INS_RD:   state_next = stat.idx_end ? ST_INS_POS : ST_INS_CHK;
            ST_INS_CHK:  state_next = stat.less ? ST_INS_RD : ST_INS_POS;
            ST_INS_POS:  state_next = ST_SHIFT_RD;
            ST_SHIFT_RD: state_next = stat.at_k ? ST_INS_WR : ST_SHIFT_WR;
            ST_SHIFT_WR: state_next = ST_SHIFT_RD;
            ST_INS_WR:   state_next = ST_DONE;
            ST_DONE:     if (stat.out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_DECODE: begin
                if (stat.op == OP_FREE) begin
                    cmd.set_full  = stat.full;
                    cmd.scan_init = !stat.full;
                end else begin
                    cmd.set_big   = stat.need_big;
                    cmd.scan_init = !stat.need_big;
                end
            end
            ST_SCAN_RD: begin
                cmd.pick_tail = stat.idx_end;
                cmd.rd_cur    = !stat.idx_end;
            end
            ST_SCAN_CHK: begin
                cmd.pick_entry = stat.fit;
                cmd.idx_inc    = !stat.fit;
            end
            ST_PAGE:   cmd.calc_limit   = 1'b1;
            ST_PLACE:  cmd.page_adjust  = 1'b1;
            ST_FINISH: cmd.finish_alloc = 1'b1;
            ST_DROP_RD: begin
                cmd.used_dec  = stat.drop_last;
                cmd.scan_init = stat.drop_last;
                cmd.rd_next   = !stat.drop_last;
            end
            ST_DROP_WR: begin
                cmd.wr_move = 1'b1;
                cmd.idx_inc = 1'b1;
            end
            ST_INS_RD: cmd.rd_cur = !stat.idx_end;
            ST_INS_CHK: begin
                cmd.ins_chk = 1'b1;
                cmd.idx_inc = stat.less;
            end
            ST_INS_POS:  cmd.ins_pos = 1'b1;
            ST_SHIFT_RD: cmd.rd_prev = !stat.at_k;
            ST_SHIFT_WR: begin
                cmd.wr_move = 1'b1;
                cmd.idx_dec = 1'b1;
            end
            ST_INS_WR: begin
                cmd.wr_ins   = 1'b1;
                cmd.used_inc = 1'b1;
            end
            ST_DONE: cmd.emit = stat.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

@@ rtl/core/bfa_datapath.sv @@
`timescale 1ns / 1ps

module bfa_datapath #(
    parameter int PAGE_BYTES   = 4096,
    parameter int FREE_ENTRIES = 64,
    parameter int HEADER_BYTES = 4
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  bfa_pkg::req_t  s_data,
    input  bfa_pkg::cmd_t  cmd,
    output bfa_pkg::stat_t stat,
    output logic           m_valid,
    input  logic           m_ready,
    output bfa_pkg::rsp_t  m_data
);
    import bfa_pkg::*;

    localparam int IW   = $clog2(FREE_ENTRIES);
    localparam int CW   = $clog2(FREE_ENTRIES + 1);
    localparam int PGW  = $clog2(PAGE_BYTES + 1);
    localparam int LW   = PAGE_BITS + 1 + PGW;
    localparam int CMPW = (LW > POS_BITS + 1) ? LW : POS_BITS + 1;
    localparam int EW   = POS_BITS + SIZE_BITS;

    logic                 op_reg;
    logic [SIZE_BITS-1:0] need_reg;
    logic [CW-1:0]        used_reg;
    logic [POS_BITS-1:0]  tail_reg;
    logic [POS_BITS-1:0]  dend_reg;
    logic [PAGE_BITS-1:0] lp_reg;
    logic [CW-1:0]        idx_reg;
    logic [CW-1:0]        k_reg;
    entry_t               ins_reg;
    logic [POS_BITS-1:0]  pos_reg;
    logic [SIZE_BITS-1:0] sz_reg;
    logic [CMPW-1:0]      limit_reg;
    logic [1:0]           status_reg;
    logic                 from_tail_reg;
    logic                 has_rem_reg;
    logic                 eq0_reg;
    logic                 m_valid_reg;
    rsp_t                 m_data_reg;

    logic [CW-1:0]        idx_p1;
    logic [CW-1:0]        idx_m1;
    logic                 rd_en;
    logic [IW-1:0]        rd_addr;
    logic [EW-1:0]        rd_raw;
    entry_t               rd_entry;
    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    logic [EW-1:0]        wr_data;
    logic [CMPW-1:0]      reach;
    logic [POS_BITS-1:0]  end_pos;
    logic [POS_BITS-1:0]  dend_new;

    assign idx_p1   = idx_reg + CW'(1);
    assign idx_m1   = idx_reg - CW'(1);
    assign rd_entry = entry_t'(rd_raw);

    always_comb begin
        rd_en   = cmd.rd_cur | cmd.rd_next | cmd.rd_prev;
        rd_addr = idx_reg[IW-1:0];
        if (cmd.rd_next) begin
            rd_addr = idx_p1[IW-1:0];
        end else if (cmd.rd_prev) begin
            rd_addr = idx_m1[IW-1:0];
        end
        wr_en   = cmd.wr_move | cmd.wr_ins;
        wr_addr = cmd.wr_ins ? k_reg[IW-1:0] : idx_reg[IW-1:0];
        wr_data = cmd.wr_ins ? EW'(ins_reg) : rd_raw;
    end

    bfa_ram #(
        .WIDTH (EW),
        .DEPTH (FREE_ENTRIES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    assign reach    = CMPW'(pos_reg) + CMPW'(need_reg);
    assign end_pos  = pos_reg + POS_BITS'(need_reg);
    assign dend_new = (end_pos > dend_reg) ? end_pos : dend_reg;

    always_comb begin
        stat.op        = op_reg;
        stat.full      = used_reg >= CW'(FREE_ENTRIES);
        stat.need_big  = 32'(need_reg) >= 32'(PAGE_BYTES);
        stat.idx_end   = idx_reg >= used_reg;
        stat.fit       = rd_entry.size >= need_reg;
        stat.less      = rd_entry.size < ins_reg.size;
        stat.drop_last = idx_p1 >= used_reg;
        stat.at_k      = idx_reg == k_reg;
        stat.from_tail = from_tail_reg;
        stat.has_rem   = has_rem_reg;
        stat.out_free  = !m_valid_reg || m_ready;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg    <= '0;
            tail_reg    <= '0;
            dend_reg    <= '0;
            lp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.used_dec) begin
                used_reg <= used_reg - CW'(1);
            end else if (cmd.used_inc) begin
                used_reg <= used_reg + CW'(1);
            end
            if (cmd.page_adjust && reach >= limit_reg) begin
                lp_reg <= lp_reg + PAGE_BITS'(1);
            end
            if (cmd.finish_alloc) begin
                dend_reg <= dend_new;
                if (from_tail_reg) begin
                    tail_reg <= dend_new;
                end
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg        <= s_data.op;
            need_reg      <= SIZE_BITS'(s_data.value_length) + SIZE_BITS'(HEADER_BYTES);
            ins_reg.start <= s_data.free_position;
            ins_reg.size  <= SIZE_BITS'(s_data.value_length);
            pos_reg       <= '0;
            status_reg    <= STAT_OK;
        end
        if (cmd.set_full) status_reg <= STAT_FULL;
        if (cmd.set_big)  status_reg <= STAT_BIG;
        if (cmd.scan_init) begin
            idx_reg <= '0;
            eq0_reg <= 1'b0;
        end
        if (cmd.idx_inc) idx_reg <= idx_p1;
        if (cmd.idx_dec) idx_reg <= idx_m1;
        if (cmd.pick_tail) begin
            pos_reg       <= tail_reg;
            from_tail_reg <= 1'b1;
        end
        if (cmd.pick_entry) begin
            pos_reg       <= rd_entry.start;
            sz_reg        <= rd_entry.size;
            k_reg         <= idx_reg;
            from_tail_reg <= 1'b0;
        end
        if (cmd.calc_limit) begin
            limit_reg <= CMPW'({1'b0, lp_reg} + (PAGE_BITS + 1)'(1)) * CMPW'(PAGE_BYTES);
        end
        // record would cross into the next page: restart at its first byte, or at 0 after the last page
        if (cmd.page_adjust && reach >= limit_reg) begin
            pos_reg <= (lp_reg == PAGE_MAX) ? '0 : limit_reg[POS_BITS-1:0];
        end
        if (cmd.finish_alloc) begin
            ins_reg.start <= end_pos;
            ins_reg.size  <= sz_reg - need_reg;
            has_rem_reg   <= sz_reg > need_reg;
            idx_reg       <= k_reg;
        end
        if (cmd.ins_chk && idx_reg == '0) begin
            eq0_reg <= rd_entry.size == ins_reg.size;
        end
        // equal to the head entry: goes right after the head
        if (cmd.ins_pos) begin
            k_reg   <= (idx_reg == '0 && used_reg != '0 && eq0_reg) ? CW'(1) : idx_reg;
            idx_reg <= used_reg;
        end
        if (cmd.emit) begin
            m_data_reg.position   <= pos_reg;
            m_data_reg.status     <= status_reg;
            m_data_reg.page_count <= lp_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ rtl/core/best_fit_free_list_allocator.sv @@
`timescale 1ns / 1ps
// the free table sits in a single-port-read ram: each scan or shift step is a read then a use;
// throughput is one request at a time, next beat taken once back in idle
// a waiting result does not block the next request beat
// reset (aresetn low, synchronous) empties the table, zeroes tail, data end and page index

module best_fit_free_list_allocator #(
    parameter int PAGE_BYTES   = 4096,
    parameter int FREE_ENTRIES = 64,
    parameter int HEADER_BYTES = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  bfa_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output bfa_pkg::rsp_t m_data
);
    import bfa_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    bfa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bfa_datapath #(
        .PAGE_BYTES   (PAGE_BYTES),
        .FREE_ENTRIES (FREE_ENTRIES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
